// File: hw/rtl/stl_pkg.sv
// ============================================================================
// stl_pkg: shared types and constants of the script token lexer
// Scan modes, token kinds and result-word layout used by the lexer files.
// ============================================================================
`default_nettype none

package stl_pkg;

    localparam int POS_BITS = 16;
    localparam int LEN_W    = 16;
    localparam int KIND_W   = 6;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    typedef enum logic [4:0] {
        M_IDLE, M_COMMENT, M_IDENT, M_ZERO, M_INT, M_DOT, M_FRAC, M_EXPS, M_EXPD,
        M_XS, M_X, M_BS, M_B, M_OS, M_O, M_STR,
        M_BANG, M_EQ, M_LT, M_GT, M_GTGT, M_AMP, M_PIPE, M_XOR1, M_XOR2
    } mode_t;

    localparam logic [KIND_W-1:0] K_END = 6'd0, K_ERR = 6'd1, K_TRUE = 6'd2,
        K_ANDAND = 6'd5, K_OROR = 6'd6, K_IDENT = 6'd12, K_NUM = 6'd13,
        K_LPAREN = 6'd14, K_RPAREN = 6'd15, K_LBRACE = 6'd16, K_RBRACE = 6'd17,
        K_COMMA = 6'd18, K_DOT = 6'd19, K_SEMI = 6'd20, K_COLON = 6'd21,
        K_QUEST = 6'd22, K_BANGEQ = 6'd23, K_BANG = 6'd24, K_EQEQ = 6'd25,
        K_EQ = 6'd26, K_SHL = 6'd27, K_LE = 6'd28, K_LT = 6'd29, K_GGG = 6'd30,
        K_GG = 6'd31, K_GE = 6'd32, K_GT = 6'd33, K_PLUS = 6'd34,
        K_MINUS = 6'd35, K_STAR = 6'd36, K_SLASH = 6'd37, K_PERCENT = 6'd38,
        K_NEWLINE = 6'd39, K_STRING = 6'd40, K_AMP = 6'd41, K_PIPE = 6'd42,
        K_CARET = 6'd43, K_TILDE = 6'd44, K_XOR = 6'd45, K_LBRACKET = 6'd46,
        K_RBRACKET = 6'd47;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [15:0]       start_offset;
        logic [LEN_W-1:0]  length;
    } tok_t;

    // keyword texts, 6 bytes, first character in the lowest byte
    typedef logic [47:0] kw_text_t;
    localparam kw_text_t KW_TEXT [10] = '{
        48'h0000_6575_7274, 48'h0065_736c_6166, 48'h0000_6c6c_756e,
        48'h0000_0064_6e61, 48'h0000_0000_726f, 48'h006e_6967_6562,
        48'h0000_0064_6e65, 48'h0000_0000_6669, 48'h6669_6573_6c65,
        48'h0000_6573_6c65};
    localparam logic [2:0] KW_LEN [10] = '{3'd4, 3'd5, 3'd4, 3'd3, 3'd2,
        3'd5, 3'd3, 3'd2, 3'd6, 3'd4};

endpackage

`default_nettype wire

// File: hw/rtl/stl_if.sv
// ============================================================================
// stl_in_if / stl_out_if: valid/ready channels of the script token lexer
// Source bytes in, tokens out.
// ============================================================================
`default_nettype none

interface stl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_input;
    modport source (output valid, ch, end_of_input, input ready);
    modport sink   (input valid, ch, end_of_input, output ready);
endinterface

interface stl_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  kind;
    logic [15:0] start_offset;
    logic [15:0] length;
    logic        last;
    modport source (output valid, kind, start_offset, length, last, input ready);
    modport sink   (input valid, kind, start_offset, length, last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/stl_step.sv
// ============================================================================
// stl_step: next-state and token logic of the lexer for one request
// Pure combinational: lexes one byte (with one re-lex) or an end mark.
// ============================================================================
`default_nettype none

module stl_step (
    input  wire stl_pkg::mode_t            mode,
    input  wire [stl_pkg::POS_BITS-1:0]    pos,
    input  wire [stl_pkg::POS_BITS-1:0]    tstart,
    input  wire [stl_pkg::LEN_W-1:0]       tlen,
    input  wire [47:0]                     kwc,
    input  wire [7:0]                      ch,
    input  wire                            eoi,
    output stl_pkg::mode_t                 mode_n,
    output logic [stl_pkg::POS_BITS-1:0]   pos_n,
    output logic [stl_pkg::POS_BITS-1:0]   tstart_n,
    output logic [stl_pkg::LEN_W-1:0]      tlen_n,
    output logic [47:0]                    kwc_n,
    output stl_pkg::tok_t                  tok [3],
    output logic [1:0]                     ntok
);
    localparam logic [stl_pkg::POS_BITS-1:0] ONE = 1;

    logic [stl_pkg::POS_BITS-1:0] pm1;
    logic [15:0] pos16, st16, pm116;
    logic [stl_pkg::LEN_W-1:0] len_inc, len_inc2;
    logic kw_hit;
    logic [stl_pkg::KIND_W-1:0] kw_kind;
    logic relex;
    logic [stl_pkg::KIND_W-1:0] one_kind;
    logic is_al, is_dg, rad_ok;
    stl_pkg::mode_t m2;

    // helpers for emitting into the result list
    function automatic stl_pkg::tok_t mk(input logic [5:0] k, input logic [15:0] s,
                                         input logic [15:0] l);
        stl_pkg::tok_t t;
        t.kind = k; t.start_offset = s; t.length = l;
        return t;
    endfunction

    assign pm1     = pos - ONE;
    assign pos16   = 16'(pos);
    assign st16    = 16'(tstart);
    assign pm116   = 16'(pm1);
    assign len_inc = (tlen == stl_pkg::LEN_MAX) ? tlen : tlen + 1'b1;
    assign len_inc2 = (len_inc == stl_pkg::LEN_MAX) ? len_inc : len_inc + 1'b1;
    assign is_al = (ch >= 8'h61 && ch <= 8'h7a) || (ch >= 8'h41 && ch <= 8'h5a) || ch == 8'h5f;
    assign is_dg = ch >= 8'h30 && ch <= 8'h39;

    // keyword lookup against the stored identifier bytes
    always_comb
    begin
        logic [47:0] msk;
        kw_hit  = 1'b0;
        kw_kind = stl_pkg::K_IDENT;
        for (int i = 9; i >= 0; i--)
        begin
            msk = 48'((49'd1 << (8 * int'(stl_pkg::KW_LEN[i]))) - 49'd1);
            if (tlen == 16'(stl_pkg::KW_LEN[i]) &&
                (kwc & msk) == stl_pkg::KW_TEXT[i])
            begin
                kw_hit  = 1'b1;
                kw_kind = stl_pkg::K_TRUE + 6'(i);
            end
        end
    end

    // single-byte token kind from idle
    always_comb
    begin
        case (ch)
            8'h28: one_kind = stl_pkg::K_LPAREN;
            8'h29: one_kind = stl_pkg::K_RPAREN;
            8'h7b: one_kind = stl_pkg::K_LBRACE;
            8'h7d: one_kind = stl_pkg::K_RBRACE;
            8'h2c: one_kind = stl_pkg::K_COMMA;
            8'h2e: one_kind = stl_pkg::K_DOT;
            8'h3b: one_kind = stl_pkg::K_SEMI;
            8'h3a: one_kind = stl_pkg::K_COLON;
            8'h3f: one_kind = stl_pkg::K_QUEST;
            8'h2b: one_kind = stl_pkg::K_PLUS;
            8'h2d: one_kind = stl_pkg::K_MINUS;
            8'h2a: one_kind = stl_pkg::K_STAR;
            8'h2f: one_kind = stl_pkg::K_SLASH;
            8'h25: one_kind = stl_pkg::K_PERCENT;
            8'h0d, 8'h0a: one_kind = stl_pkg::K_NEWLINE;
            8'h5e: one_kind = stl_pkg::K_CARET;
            8'h7e: one_kind = stl_pkg::K_TILDE;
            8'h5b: one_kind = stl_pkg::K_LBRACKET;
            8'h5d: one_kind = stl_pkg::K_RBRACKET;
            default: one_kind = stl_pkg::K_ERR;
        endcase
    end

    always_comb
    begin
        case (mode)
            stl_pkg::M_XS, stl_pkg::M_X:
                rad_ok = is_dg || (ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46);
            stl_pkg::M_BS, stl_pkg::M_B: rad_ok = ch == 8'h30 || ch == 8'h31;
            default: rad_ok = ch >= 8'h30 && ch <= 8'h37;
        endcase
    end

    // main step: pending-mode handling, flush, then idle lexing of the byte
    always_comb
    begin
        logic [5:0] fk;
        mode_n   = mode;
        pos_n    = pos + ONE;
        tstart_n = tstart;
        tlen_n   = tlen;
        kwc_n    = kwc;
        tok[0]   = '0; tok[1] = '0; tok[2] = '0;
        ntok     = 2'd0;
        relex    = 1'b0;
        m2       = mode;
        fk       = stl_pkg::K_NUM;

        // first pass over the pending mode
        case (mode)
            stl_pkg::M_IDLE: relex = 1'b1;
            stl_pkg::M_COMMENT: if (ch == 8'h0a) mode_n = stl_pkg::M_IDLE;
            stl_pkg::M_IDENT:
                if (is_al || is_dg)
                begin
                    if (tlen < 16'd6) kwc_n[8*tlen[2:0] +: 8] = ch;
                    tlen_n = len_inc;
                end
                else relex = 1'b1;
            stl_pkg::M_ZERO, stl_pkg::M_INT:
                if (mode == stl_pkg::M_ZERO && ch == 8'h78)
                begin tlen_n = len_inc; mode_n = stl_pkg::M_XS; end
                else if (mode == stl_pkg::M_ZERO && ch == 8'h62)
                begin tlen_n = len_inc; mode_n = stl_pkg::M_BS; end
                else if (mode == stl_pkg::M_ZERO && ch == 8'h6f)
                begin tlen_n = len_inc; mode_n = stl_pkg::M_OS; end
                else if (is_dg)
                begin tlen_n = len_inc; mode_n = stl_pkg::M_INT; end
                else if (ch == 8'h2e) mode_n = stl_pkg::M_DOT;
                else if (ch == 8'h65 || ch == 8'h45)
                begin tlen_n = len_inc; mode_n = stl_pkg::M_EXPS; end
                else relex = 1'b1;
            stl_pkg::M_DOT:
                if (is_dg) begin tlen_n = len_inc2; mode_n = stl_pkg::M_FRAC; end
                else relex = 1'b1;
            stl_pkg::M_FRAC:
                if (is_dg) tlen_n = len_inc;
                else if (ch == 8'h65 || ch == 8'h45)
                begin tlen_n = len_inc; mode_n = stl_pkg::M_EXPS; end
                else relex = 1'b1;
            stl_pkg::M_EXPS:
                if (ch == 8'h2b || ch == 8'h2d || is_dg)
                begin tlen_n = len_inc; mode_n = stl_pkg::M_EXPD; end
                else relex = 1'b1;
            stl_pkg::M_EXPD:
                if (is_dg) tlen_n = len_inc; else relex = 1'b1;
            stl_pkg::M_XS:
                if (rad_ok) begin tlen_n = len_inc; mode_n = stl_pkg::M_X; end
                else relex = 1'b1;
            stl_pkg::M_BS:
                if (rad_ok) begin tlen_n = len_inc; mode_n = stl_pkg::M_B; end
                else relex = 1'b1;
            stl_pkg::M_OS:
                if (rad_ok) begin tlen_n = len_inc; mode_n = stl_pkg::M_O; end
                else relex = 1'b1;
            stl_pkg::M_X, stl_pkg::M_B, stl_pkg::M_O:
                if (rad_ok) tlen_n = len_inc; else relex = 1'b1;
            stl_pkg::M_STR:
                if (ch == 8'h22)
                begin
                    tok[0] = mk(stl_pkg::K_STRING, st16, tlen); ntok = 2'd1;
                    mode_n = stl_pkg::M_IDLE;
                end
                else tlen_n = len_inc;
            stl_pkg::M_BANG:
                if (ch == 8'h3d)
                begin tok[0] = mk(stl_pkg::K_BANGEQ, st16, 16'd2); ntok = 2'd1;
                      mode_n = stl_pkg::M_IDLE; end
                else relex = 1'b1;
            stl_pkg::M_EQ:
                if (ch == 8'h3d)
                begin tok[0] = mk(stl_pkg::K_EQEQ, st16, 16'd2); ntok = 2'd1;
                      mode_n = stl_pkg::M_IDLE; end
                else relex = 1'b1;
            stl_pkg::M_LT:
                if (ch == 8'h3c || ch == 8'h3d)
                begin
                    tok[0] = mk(ch == 8'h3c ? stl_pkg::K_SHL : stl_pkg::K_LE, st16, 16'd2);
                    ntok = 2'd1; mode_n = stl_pkg::M_IDLE;
                end
                else relex = 1'b1;
            stl_pkg::M_GT:
                if (ch == 8'h3e) begin tlen_n = len_inc; mode_n = stl_pkg::M_GTGT; end
                else if (ch == 8'h3d)
                begin tok[0] = mk(stl_pkg::K_GE, st16, 16'd2); ntok = 2'd1;
                      mode_n = stl_pkg::M_IDLE; end
                else relex = 1'b1;
            stl_pkg::M_GTGT:
                if (ch == 8'h3e)
                begin tok[0] = mk(stl_pkg::K_GGG, st16, 16'd3); ntok = 2'd1;
                      mode_n = stl_pkg::M_IDLE; end
                else relex = 1'b1;
            stl_pkg::M_AMP:
                if (ch == 8'h26)
                begin tok[0] = mk(stl_pkg::K_ANDAND, st16, 16'd2); ntok = 2'd1;
                      mode_n = stl_pkg::M_IDLE; end
                else relex = 1'b1;
            stl_pkg::M_PIPE:
                if (ch == 8'h7c)
                begin tok[0] = mk(stl_pkg::K_OROR, st16, 16'd2); ntok = 2'd1;
                      mode_n = stl_pkg::M_IDLE; end
                else relex = 1'b1;
            stl_pkg::M_XOR1:
                if (ch == 8'h8a) begin tlen_n = len_inc; mode_n = stl_pkg::M_XOR2; end
                else relex = 1'b1;
            stl_pkg::M_XOR2:
                if (ch == 8'hbb)
                begin tok[0] = mk(stl_pkg::K_XOR, st16, 16'd3); ntok = 2'd1;
                      mode_n = stl_pkg::M_IDLE; end
                else relex = 1'b1;
            default: relex = 1'b1;
        endcase

        // flush of the pending token (byte relex or end mark)
        if ((relex && mode != stl_pkg::M_IDLE) || eoi)
        begin
            ntok = 2'd0;
            case (mode)
                stl_pkg::M_IDENT:
                begin
                    tok[0] = mk(kw_hit ? kw_kind : stl_pkg::K_IDENT, st16, tlen);
                    ntok = 2'd1;
                end
                stl_pkg::M_ZERO, stl_pkg::M_INT, stl_pkg::M_FRAC, stl_pkg::M_EXPS,
                stl_pkg::M_EXPD, stl_pkg::M_X, stl_pkg::M_B, stl_pkg::M_O:
                begin tok[0] = mk(stl_pkg::K_NUM, st16, tlen); ntok = 2'd1; end
                stl_pkg::M_DOT:
                begin
                    tok[0] = mk(stl_pkg::K_NUM, st16, tlen);
                    tok[1] = mk(stl_pkg::K_DOT, pm116, 16'd1); ntok = 2'd2;
                end
                stl_pkg::M_XS, stl_pkg::M_BS, stl_pkg::M_OS, stl_pkg::M_STR,
                stl_pkg::M_XOR1:
                begin tok[0] = mk(stl_pkg::K_ERR, st16, tlen); ntok = 2'd1; end
                stl_pkg::M_XOR2:
                begin
                    tok[0] = mk(stl_pkg::K_ERR, st16, 16'd1);
                    tok[1] = mk(stl_pkg::K_ERR, pm116, 16'd1); ntok = 2'd2;
                end
                stl_pkg::M_BANG, stl_pkg::M_EQ, stl_pkg::M_LT, stl_pkg::M_GT,
                stl_pkg::M_AMP, stl_pkg::M_PIPE:
                begin
                    case (mode)
                        stl_pkg::M_BANG: fk = stl_pkg::K_BANG;
                        stl_pkg::M_EQ:   fk = stl_pkg::K_EQ;
                        stl_pkg::M_LT:   fk = stl_pkg::K_LT;
                        stl_pkg::M_GT:   fk = stl_pkg::K_GT;
                        stl_pkg::M_AMP:  fk = stl_pkg::K_AMP;
                        default:         fk = stl_pkg::K_PIPE;
                    endcase
                    tok[0] = mk(fk, st16, 16'd1); ntok = 2'd1;
                end
                stl_pkg::M_GTGT:
                begin tok[0] = mk(stl_pkg::K_GG, st16, 16'd2); ntok = 2'd1; end
                default: ntok = 2'd0;
            endcase
            mode_n = stl_pkg::M_IDLE;
            tstart_n = tstart; tlen_n = tlen; kwc_n = kwc;
        end

        // end mark: end token then full restart
        if (eoi)
        begin
            tok[ntok] = mk(stl_pkg::K_END, pos16, 16'd0);
            ntok      = ntok + 2'd1;
            mode_n    = stl_pkg::M_IDLE;
            pos_n     = '0;
            tstart_n  = '0;
            tlen_n    = '0;
            kwc_n     = '0;
        end
        else if (relex)
        begin
            // idle lexing of the byte
            m2 = stl_pkg::M_IDLE;
            if (ch == 8'h20 || ch == 8'h09) m2 = stl_pkg::M_IDLE;
            else if (ch == 8'h23) m2 = stl_pkg::M_COMMENT;
            else if (is_al)
            begin
                m2 = stl_pkg::M_IDENT; kwc_n[7:0] = ch;
            end
            else if (is_dg) m2 = (ch == 8'h30) ? stl_pkg::M_ZERO : stl_pkg::M_INT;
            else if (ch == 8'h22) m2 = stl_pkg::M_STR;
            else if (ch == 8'h21) m2 = stl_pkg::M_BANG;
            else if (ch == 8'h3d) m2 = stl_pkg::M_EQ;
            else if (ch == 8'h3c) m2 = stl_pkg::M_LT;
            else if (ch == 8'h3e) m2 = stl_pkg::M_GT;
            else if (ch == 8'h26) m2 = stl_pkg::M_AMP;
            else if (ch == 8'h7c) m2 = stl_pkg::M_PIPE;
            else if (ch == 8'he2) m2 = stl_pkg::M_XOR1;
            else
            begin
                tok[ntok] = mk(one_kind, pos16, 16'd1);
                ntok      = ntok + 2'd1;
            end
            mode_n = m2;
            if (ch == 8'h22)
            begin
                tstart_n = pos + ONE; tlen_n = '0;
            end
            else if (m2 != stl_pkg::M_IDLE && m2 != stl_pkg::M_COMMENT)
            begin
                tstart_n = pos; tlen_n = 16'd1;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/script_token_lexer_top.sv
// ============================================================================
// script_token_lexer_top: streaming lexer, one source byte per request
// Holds the scan state and a three-entry result buffer toward the sink.
// ============================================================================
// Usage:
//   src: one request per source byte (ch) or an end mark (end_of_input).
//   tok: tokens as kind, start_offset, length; last marks the final token
//        caused by one input request. A request gives 0 to 3 tokens.
// Latency: the first token of a request is offered the cycle after accept.
// Throughput: one request per cycle while the sink takes each token at once;
//   a request that gives more than one token holds the channel while the
//   single output port drains the result buffer.
// The scan-state update is a single combinational pass in front of the
// state registers, so a new byte may be taken while the result buffer still
// holds its last token (that slot frees at the same edge it is taken).
// Reset: scan state idle, position zero, buffer empty.
// Sink stall: the buffer holds its tokens and src.ready drops until only
//   the last token is left being taken.
// ============================================================================
`default_nettype none

module script_token_lexer_top (
    input  wire     clk,
    input  wire     rst_n,
    stl_in_if.sink  src,
    stl_out_if.source tok
);
    stl_pkg::mode_t                mode_reg, mode_next;
    logic [stl_pkg::POS_BITS-1:0]  pos_reg, pos_next;
    logic [stl_pkg::POS_BITS-1:0]  tstart_reg, tstart_next;
    logic [stl_pkg::LEN_W-1:0]     tlen_reg, tlen_next;
    logic [47:0]                   kwc_reg, kwc_next;

    stl_pkg::tok_t buf_reg [3];
    stl_pkg::tok_t tok_new [3];
    logic [1:0]    cnt_reg;     // tokens still waiting
    logic [1:0]    rd_reg;      // index of the head token
    logic [1:0]    ntok;
    logic          acc, pop;

    stl_step u_step (
        .mode(mode_reg), .pos(pos_reg), .tstart(tstart_reg), .tlen(tlen_reg),
        .kwc(kwc_reg), .ch(src.ch), .eoi(src.end_of_input),
        .mode_n(mode_next), .pos_n(pos_next), .tstart_n(tstart_next),
        .tlen_n(tlen_next), .kwc_n(kwc_next), .tok(tok_new), .ntok(ntok)
    );

    // handshakes
    assign pop       = tok.valid && tok.ready;
    assign src.ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && tok.ready);
    assign acc       = src.valid && src.ready;

    // output view of the head token
    assign tok.valid        = cnt_reg != 2'd0;
    assign tok.kind         = buf_reg[rd_reg].kind;
    assign tok.start_offset = buf_reg[rd_reg].start_offset;
    assign tok.length       = buf_reg[rd_reg].length;
    assign tok.last         = cnt_reg == 2'd1;

    // scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= stl_pkg::M_IDLE;
            pos_reg    <= '0;
            tstart_reg <= '0;
            tlen_reg   <= '0;
        end
        else if (acc)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            tstart_reg <= tstart_next;
            tlen_reg   <= tlen_next;
        end
    end

    // identifier bytes and token payloads
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            kwc_reg <= kwc_next;
            buf_reg <= tok_new;
        end
    end

    // buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 2'd0;
        end
        else if (acc)
        begin
            cnt_reg <= ntok;
            rd_reg  <= 2'd0;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
            rd_reg  <= rd_reg + 2'd1;
        end
    end

`ifndef SYNTH
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        acc |-> (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop)))
        else $error("request taken over unsent tokens");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3 || rd_reg == 2'd0)
        else $error("token buffer index out of step");
    a_eoi_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && src.end_of_input) |=> (pos_reg == '0 && mode_reg == stl_pkg::M_IDLE))
        else $error("end mark did not restart the scan");
    a_eoi_tok: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && src.end_of_input) |=> cnt_reg != 2'd0)
        else $error("end mark gave no end token");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_script_token_lexer_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_script_token_lexer_top: self-checking bench of the script token lexer
// Drives source bytes and end marks through the request channel, predicts the
// tokens with a behavioural lexer model and checks every token in order.
// Directed table first, then a sink hold-off, then random source fragments and noise.
// ============================================================================
`default_nettype none

module tb_script_token_lexer_top;
    import stl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [15:0] NO_CHECK = 16'hFFFF;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start_offset;
        logic [15:0] length;
        logic        last;
    } token_t;

    typedef struct {
        logic [7:0]  ch;
        logic        eoi;
        logic [5:0]  kind0;     // typed first token; K_END with flag off = predictor only
        logic [15:0] len0;
        logic        typed;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    stl_in_if  src ();
    stl_out_if tok ();

    script_token_lexer_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src),
        .tok   (tok)
    );

    always #1 clk = ~clk;

    // lexer predictor state
    mode_t       lx_mode;
    logic [15:0] lx_pos;
    logic [15:0] lx_start;
    logic [15:0] lx_len;
    logic [7:0]  lx_kw [6];

    token_t      step_toks [$];
    token_t      pending_tokens [$];
    int          errors = 0;
    int          tokens_seen = 0;
    int          requests_sent = 0;
    int          cycles = 0;
    bit          calm = 1'b0;
    bit          hold_sink = 1'b0;
    bit          stim_done = 1'b0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void push_tok(logic [5:0] k, logic [15:0] s, logic [15:0] l);
        token_t t;
        if (step_toks.size() >= 3)
            return;
        t.kind = k;
        t.start_offset = s;
        t.length = l;
        t.last = 1'b0;
        step_toks.push_back(t);
    endfunction

    function automatic void grow_len();
        if (lx_len != LEN_MAX)
            lx_len++;
    endfunction

    function automatic void open_tok(logic [15:0] p, mode_t m);
        lx_start = p;
        lx_len = 16'd1;
        lx_mode = m;
    endfunction

    function automatic void emit_word();
        bit hit;
        if (lx_len <= 16'd6) begin
            for (int i = 0; i < 10; i++) begin
                hit = (KW_LEN[i] == lx_len[2:0]);
                for (int j = 0; j < 6; j++)
                    if (j < KW_LEN[i] && lx_kw[j] != KW_TEXT[i][8*j +: 8])
                        hit = 1'b0;
                if (hit) begin
                    push_tok(K_TRUE + 6'(i), lx_start, lx_len);
                    return;
                end
            end
        end
        push_tok(K_IDENT, lx_start, lx_len);
    endfunction

    function automatic void lex_idle(logic [7:0] c, logic [15:0] p);
        logic [5:0] k;
        if (c == " " || c == 8'h09)
            return;
        if (c == "#") begin
            lx_mode = M_COMMENT;
            return;
        end
        if (is_alpha(c)) begin
            open_tok(p, M_IDENT);
            lx_kw[0] = c;
            return;
        end
        if (is_digit(c)) begin
            open_tok(p, c == "0" ? M_ZERO : M_INT);
            return;
        end
        case (c)
            "\"":
            begin
                lx_start = p + 16'd1;
                lx_len = 16'd0;
                lx_mode = M_STR;
                return;
            end
            "!": begin open_tok(p, M_BANG); return; end
            "=": begin open_tok(p, M_EQ); return; end
            "<": begin open_tok(p, M_LT); return; end
            ">": begin open_tok(p, M_GT); return; end
            "&": begin open_tok(p, M_AMP); return; end
            "|": begin open_tok(p, M_PIPE); return; end
            8'hE2: begin open_tok(p, M_XOR1); return; end
            "(": k = K_LPAREN;
            ")": k = K_RPAREN;
            "{": k = K_LBRACE;
            "}": k = K_RBRACE;
            ",": k = K_COMMA;
            ".": k = K_DOT;
            ";": k = K_SEMI;
            ":": k = K_COLON;
            "?": k = K_QUEST;
            "+": k = K_PLUS;
            "-": k = K_MINUS;
            "*": k = K_STAR;
            "/": k = K_SLASH;
            "%": k = K_PERCENT;
            8'h0D, 8'h0A: k = K_NEWLINE;
            "^": k = K_CARET;
            "~": k = K_TILDE;
            "[": k = K_LBRACKET;
            "]": k = K_RBRACKET;
            default: k = K_ERR;
        endcase
        push_tok(k, p, 16'd1);
    endfunction

    // close whatever is pending; the previous byte sat at p-1
    function automatic void close_pending(logic [15:0] p);
        case (lx_mode)
            M_IDENT: emit_word();
            M_ZERO, M_INT, M_FRAC, M_EXPS, M_EXPD, M_X, M_B, M_O:
                push_tok(K_NUM, lx_start, lx_len);
            M_DOT:
            begin
                push_tok(K_NUM, lx_start, lx_len);
                push_tok(K_DOT, p - 16'd1, 16'd1);
            end
            M_XS, M_BS, M_OS, M_STR, M_XOR1: push_tok(K_ERR, lx_start, lx_len);
            M_XOR2:
            begin
                push_tok(K_ERR, lx_start, 16'd1);
                push_tok(K_ERR, p - 16'd1, 16'd1);
            end
            M_BANG: push_tok(K_BANG, lx_start, 16'd1);
            M_EQ:   push_tok(K_EQ, lx_start, 16'd1);
            M_LT:   push_tok(K_LT, lx_start, 16'd1);
            M_GT:   push_tok(K_GT, lx_start, 16'd1);
            M_GTGT: push_tok(K_GG, lx_start, 16'd2);
            M_AMP:  push_tok(K_AMP, lx_start, 16'd1);
            M_PIPE: push_tok(K_PIPE, lx_start, 16'd1);
            default: ;
        endcase
        lx_mode = M_IDLE;
    endfunction

    function automatic bit digit_ok(mode_t m, logic [7:0] c);
        if (m == M_XS || m == M_X)
            return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        if (m == M_BS || m == M_B)
            return c == "0" || c == "1";
        return c >= "0" && c <= "7";
    endfunction

    function automatic void pair_done(logic [5:0] k);
        push_tok(k, lx_start, 16'd2);
        lx_mode = M_IDLE;
    endfunction

    // returns 0 when c ended the pending token and must be lexed again
    function automatic bit lex_byte(logic [7:0] c, logic [15:0] p);
        mode_t m;
        m = lx_mode;
        case (m)
            M_IDLE: begin lex_idle(c, p); return 1'b1; end
            M_COMMENT:
            begin
                if (c == 8'h0A)
                    lx_mode = M_IDLE;
                return 1'b1;
            end
            M_IDENT:
                if (is_alpha(c) || is_digit(c)) begin
                    if (lx_len < 16'd6)
                        lx_kw[lx_len[2:0]] = c;
                    grow_len();
                    return 1'b1;
                end
            M_ZERO, M_INT:
            begin
                if (m == M_ZERO && (c == "x" || c == "b" || c == "o")) begin
                    grow_len();
                    lx_mode = (c == "x") ? M_XS : (c == "b") ? M_BS : M_OS;
                    return 1'b1;
                end
                if (is_digit(c)) begin grow_len(); lx_mode = M_INT; return 1'b1; end
                if (c == ".") begin lx_mode = M_DOT; return 1'b1; end
                if (c == "e" || c == "E") begin grow_len(); lx_mode = M_EXPS; return 1'b1; end
            end
            M_DOT:
                if (is_digit(c)) begin
                    grow_len();
                    grow_len();
                    lx_mode = M_FRAC;
                    return 1'b1;
                end
            M_FRAC:
            begin
                if (is_digit(c)) begin grow_len(); return 1'b1; end
                if (c == "e" || c == "E") begin grow_len(); lx_mode = M_EXPS; return 1'b1; end
            end
            M_EXPS:
                if (c == "+" || c == "-" || is_digit(c)) begin
                    grow_len();
                    lx_mode = M_EXPD;
                    return 1'b1;
                end
            M_EXPD:
                if (is_digit(c)) begin grow_len(); return 1'b1; end
            M_XS, M_BS, M_OS:
                if (digit_ok(m, c)) begin
                    grow_len();
                    lx_mode = mode_t'(m + 1);
                    return 1'b1;
                end
            M_X, M_B, M_O:
                if (digit_ok(m, c)) begin grow_len(); return 1'b1; end
            M_STR:
            begin
                if (c == "\"") begin
                    push_tok(K_STRING, lx_start, lx_len);
                    lx_mode = M_IDLE;
                end
                else
                    grow_len();
                return 1'b1;
            end
            M_BANG: if (c == "=") begin pair_done(K_BANGEQ); return 1'b1; end
            M_EQ:   if (c == "=") begin pair_done(K_EQEQ); return 1'b1; end
            M_LT:
            begin
                if (c == "<") begin pair_done(K_SHL); return 1'b1; end
                if (c == "=") begin pair_done(K_LE); return 1'b1; end
            end
            M_GT:
            begin
                if (c == ">") begin grow_len(); lx_mode = M_GTGT; return 1'b1; end
                if (c == "=") begin pair_done(K_GE); return 1'b1; end
            end
            M_GTGT:
                if (c == ">") begin
                    push_tok(K_GGG, lx_start, 16'd3);
                    lx_mode = M_IDLE;
                    return 1'b1;
                end
            M_AMP:  if (c == "&") begin pair_done(K_ANDAND); return 1'b1; end
            M_PIPE: if (c == "|") begin pair_done(K_OROR); return 1'b1; end
            M_XOR1:
                if (c == 8'h8A) begin grow_len(); lx_mode = M_XOR2; return 1'b1; end
            M_XOR2:
                if (c == 8'hBB) begin
                    push_tok(K_XOR, lx_start, 16'd3);
                    lx_mode = M_IDLE;
                    return 1'b1;
                end
            default: begin lx_mode = M_IDLE; return 1'b0; end
        endcase
        close_pending(p);
        return 1'b0;
    endfunction

    function automatic void lexer_clear();
        lx_mode = M_IDLE;
        lx_pos = '0;
        lx_start = '0;
        lx_len = '0;
        for (int i = 0; i < 6; i++)
            lx_kw[i] = 8'h00;
    endfunction

    // predict the tokens of one request into step_toks
    function automatic void predict_request(logic [7:0] c, logic eoi);
        step_toks.delete();
        if (eoi) begin
            close_pending(lx_pos);
            push_tok(K_END, lx_pos, 16'd0);
            lexer_clear();
        end
        else begin
            if (!lex_byte(c, lx_pos))
                void'(lex_byte(c, lx_pos));
            lx_pos++;
        end
        if (step_toks.size() > 0)
            step_toks[step_toks.size()-1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------
    task automatic sender_gap();
        int n;
        if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 3);
            src.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_request(logic [7:0] c, logic eoi, bit typed,
                                logic [5:0] k0, logic [15:0] l0);
        sender_gap();
        src.valid <= 1'b1;
        src.ch <= c;
        src.end_of_input <= eoi;
        predict_request(c, eoi);
        if (typed) begin
            if (step_toks.size() == 0 || step_toks[0].kind != k0) begin
                errors++;
                $error("kind: expected %0d, actual %0d", k0,
                       step_toks.size() ? step_toks[0].kind : 6'h3F);
            end
            else if (l0 != NO_CHECK && step_toks[0].length != l0) begin
                errors++;
                $error("length: expected %0d, actual %0d", l0, step_toks[0].length);
            end
        end
        foreach (step_toks[i])
            pending_tokens.push_back(step_toks[i]);
        do
            @(posedge clk);
        while (!src.ready);
        requests_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_request(s[i], 1'b0, 1'b0, K_END, NO_CHECK);
    endtask

    task automatic send_end();
        send_request(8'h00, 1'b1, 1'b0, K_END, NO_CHECK);
    endtask

    task automatic drain_wait();
        src.valid <= 1'b0;
        while (pending_tokens.size() > 0)
            @(posedge clk);
    endtask

    function automatic string random_fragment();
        string pool [] = '{"if", "elseif", "else", "begin", "end", "true",
            "false", "null", "and", "or", "x_1", "abcdefgh", "0x1F", "0b101",
            "0o17", "0x", "0b2", "0o9", "12.5e-3", "7.", "3.x", "1e+", "0",
            "\"hi\"", "\"\"", "!=", "==", "<<", "<=", ">>>", ">>", ">=", ">",
            "&&", "||", "&", "|", "=", "!", "<", "# note\n", "\r\n", "\t",
            "(", ")", "{", "}", "[", "]", ",", ";", ":", "?", "+", "-",
            "*", "/", "%", "^", "~", "@", "$"};
        return pool[$urandom_range(0, pool.size()-1)];
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    row_t table_rows [$];

    function automatic void add_row(logic [7:0] c, logic e, bit t, logic [5:0] k, logic [15:0] l);
        row_t r;
        r.ch = c;
        r.eoi = e;
        r.typed = t;
        r.kind0 = k;
        r.len0 = l;
        table_rows.push_back(r);
    endfunction

    initial begin
        string frag;
        int n;
        src.valid = 1'b0;
        src.ch = 8'h00;
        src.end_of_input = 1'b0;
        lexer_clear();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: extremes, error codes, special cases
        add_row(8'h00, 1'b1, 1'b1, K_END, 16'd0);     // end right after reset
        add_row(8'h00, 1'b0, 1'b1, K_ERR, 16'd1);     // unknown byte, lowest
        add_row(8'hFF, 1'b0, 1'b1, K_ERR, 16'd1);     // unknown byte, highest
        add_row("0", 1'b0, 1'b0, K_END, 16'd0);
        add_row("x", 1'b0, 1'b0, K_END, 16'd0);
        add_row(";", 1'b0, 1'b1, K_ERR, 16'd2);       // radix prefix, no digit
        add_row(8'hE2, 1'b0, 1'b0, K_END, 16'd0);
        add_row(8'h8A, 1'b0, 1'b0, K_END, 16'd0);
        add_row("a", 1'b0, 1'b1, K_ERR, 16'd1);       // broken xor sign
        add_row(8'hE2, 1'b0, 1'b1, K_IDENT, 16'd1);
        add_row(8'h8A, 1'b0, 1'b0, K_END, 16'd0);
        add_row(8'hBB, 1'b0, 1'b1, K_XOR, 16'd3);
        add_row("5", 1'b0, 1'b0, K_END, 16'd0);
        add_row(".", 1'b0, 1'b0, K_END, 16'd0);
        add_row("+", 1'b0, 1'b1, K_NUM, 16'd1);       // dot with no fraction digit
        add_row("\"", 1'b0, 1'b0, K_END, 16'd0);
        add_row("q", 1'b0, 1'b0, K_END, 16'd0);
        add_row(8'h00, 1'b1, 1'b1, K_ERR, 16'd1);     // open string at end
        add_row(8'hE2, 1'b0, 1'b0, K_END, 16'd0);
        add_row(8'h00, 1'b1, 1'b1, K_ERR, 16'd1);
        foreach (table_rows[i])
            send_request(table_rows[i].ch, table_rows[i].eoi, table_rows[i].typed,
                         table_rows[i].kind0, table_rows[i].len0);

        // sender pause until every token is out
        drain_wait();

        // long sink hold-off while the sender keeps offering lookahead-heavy bytes
        hold_sink = 1'b1;
        send_text("7.;0x;>>");
        hold_sink = 1'b0;
        send_end();

        // random part: mostly source fragments, some raw noise and end marks
        while (requests_sent < 380) begin
            if (requests_sent > 330)
                calm = 1'b1;
            n = $urandom_range(0, 9);
            if (n < 7) begin
                frag = random_fragment();
                send_text(frag);
                if ($urandom_range(0, 1))
                    send_text(" ");
            end
            else if (n < 9)
                send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0, K_END, NO_CHECK);
            else
                send_end();
        end
        send_end();
        src.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // long stretch of sink hold-off, counted in its own process
    int hold_count = 0;
    always @(posedge clk) begin
        if (hold_sink && hold_count < 40)
            hold_count <= hold_count + 1;
    end

    // sink side: random stall bursts, long hold when asked
    int stall_left = 0;
    initial begin
        tok.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_sink && hold_count < 40)
                tok.ready <= 1'b0;
            else if (stall_left > 0) begin
                stall_left--;
                tok.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 2);
                tok.ready <= 1'b0;
            end
            else
                tok.ready <= 1'b1;
        end
    end

    // token checker
    always @(posedge clk) begin
        token_t want;
        if (rst_n && tok.valid && tok.ready) begin
            tokens_seen++;
            if (pending_tokens.size() == 0) begin
                errors++;
                $error("token with nothing expected: kind %0d", tok.kind);
            end
            else begin
                want = pending_tokens.pop_front();
                if (tok.kind !== want.kind) begin
                    errors++;
                    $error("kind: expected %0d, actual %0d", want.kind, tok.kind);
                end
                if (tok.start_offset !== want.start_offset) begin
                    errors++;
                    $error("start_offset: expected %0d, actual %0d",
                           want.start_offset, tok.start_offset);
                end
                if (tok.length !== want.length) begin
                    errors++;
                    $error("length: expected %0d, actual %0d", want.length, tok.length);
                end
                if (tok.last !== want.last) begin
                    errors++;
                    $error("last: expected %0d, actual %0d", want.last, tok.last);
                end
            end
        end
    end

    // end of run and timeout
    initial begin
        wait (stim_done);
        while (pending_tokens.size() > 0 && cycles < CYCLE_LIMIT)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (cycles >= CYCLE_LIMIT)
            errors++;
        $display("Lexed %0d source requests into %0d tokens, covering keywords, numbers,",
                 requests_sent, tokens_seen);
        $display("strings, operators, broken sequences and sink stalls.");
        if (errors == 0 && pending_tokens.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT + 100) begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule

`default_nettype wire
